[src/polyphonic_dds_mixer_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the polyphonic DDS mixer
// Short forms for clocked implication checks with an async low reset.
// ----------------------------------------------------------------------------
`ifndef POLYPHONIC_DDS_MIXER_MACROS_SVH
`define POLYPHONIC_DDS_MIXER_MACROS_SVH

// Same-cycle implication.
`define PDM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PDM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/pdm_pkg.sv]
// ----------------------------------------------------------------------------
// pdm_pkg
// Shared sizes, types, sine table and helper functions of the DDS mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package pdm_pkg;

  // Bank geometry.
  localparam int Keys          = 12;
  localparam int Octaves       = 4;
  localparam int SineDepth     = 256;
  localparam int PhaseFracBits = 16;

  // Port field widths.
  localparam int MaskW    = 12;
  localparam int OctaveW  = 2;
  localparam int VolW     = 12;
  localparam int StepIdxW = 6;
  localparam int StepW    = 24;
  localparam int DacW     = 8;
  localparam int CountW   = 4;

  // Internal widths.
  localparam int SampleW    = 16;
  localparam int RomAddrW   = 8;
  localparam int QuarterLen = 64;
  localparam int PosW       = $clog2(SineDepth);
  localparam int PhaseW     = PosW + PhaseFracBits;
  localparam int OctSelW    = (Octaves > 1) ? $clog2(Octaves) : 1;
  localparam int CntW       = $clog2(Keys + 1);
  localparam int SumW       = SampleW + $clog2(Keys + 1);
  localparam int MagW       = SumW - 1;
  localparam int ProdW      = MagW + VolW;
  localparam int GroupSize  = 4;
  localparam int NumGroups  = (Keys + GroupSize - 1) / GroupSize;

  // Mix scaling: divide by 4 * 4095 through a reciprocal multiply. With the
  // shift one past the product width the estimate is low by at most one.
  localparam int MixDivisor = 16380;
  localparam int RecipShift = ProdW + 1;
  localparam int RecipW     = RecipShift - $clog2(MixDivisor) + 1;
  localparam logic [RecipW-1:0] MixRecip =
    RecipW'((64'd1 << RecipShift) / 64'(MixDivisor));
  localparam int EstW       = ProdW + RecipW;
  localparam int QW         = EstW - RecipShift;

  localparam int SampleMax = 32767;
  localparam int DacMid    = 32768;
  localparam logic [DacW-1:0] DacSilence = 8'd128;

  typedef enum logic {
    OpRender = 1'b0,
    OpLoad   = 1'b1
  } op_e;

  typedef struct packed {
    logic               held;
    logic [SampleW-1:0] sample;
  } lane_out_t;

  localparam logic signed [SampleW-1:0] QuarterWave [QuarterLen+1] = '{
        0,   804,  1608,  2410,  3212,  4011,  4808,  5602,
     6393,  7179,  7962,  8739,  9512, 10278, 11039, 11793,
    12539, 13278, 14010, 14732, 15446, 16151, 16846, 17530,
    18204, 18868, 19519, 20159, 20787, 21403, 22005, 22594,
    23170, 23731, 24279, 24811, 25329, 25832, 26319, 26790,
    27245, 27683, 28105, 28510, 28898, 29268, 29621, 29956,
    30273, 30571, 30851, 31113, 31356, 31580, 31785, 31971,
    32137, 32285, 32412, 32521, 32609, 32678, 32728, 32757,
    32767
  };

  // Full sine period rebuilt from the quarter wave by symmetry.
  function automatic logic signed [SampleW-1:0] sine_lookup(input logic [RomAddrW-1:0] addr);
    logic [1:0]                quad;
    logic [5:0]                r;
    logic [6:0]                idx;
    logic signed [SampleW-1:0] v;
    quad = addr[7:6];
    r    = addr[5:0];
    idx  = quad[0] ? 7'(7'(QuarterLen) - {1'b0, r}) : {1'b0, r};
    v    = QuarterWave[idx];
    return quad[1] ? -v : v;
  endfunction

  // Scales an integer phase position onto the 256-entry table.
  function automatic logic [RomAddrW-1:0] rom_addr(input logic [PosW-1:0] pos);
    logic [PosW+RomAddrW-1:0] wide;
    wide = {pos, {RomAddrW{1'b0}}} >> PosW;
    return wide[RomAddrW-1:0];
  endfunction

endpackage

`default_nettype wire

[src/pdm_lane.sv]
// ----------------------------------------------------------------------------
// pdm_lane
// One key: its oscillators across all octaves, sine lookup and phase step.
// ----------------------------------------------------------------------------
`default_nettype none

module pdm_lane import pdm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               render_i,
  input  logic               held_i,
  input  logic [OctSelW-1:0] oct_i,
  input  logic [Octaves-1:0] load_we_i,
  input  logic [StepW-1:0]   step_value_i,
  output lane_out_t          lane_o
);

  logic [PhaseW-1:0] acc_q [Octaves];
  logic [PhaseW-1:0] acc_d [Octaves];
  logic [PhaseW-1:0] inc_q [Octaves];
  logic [PhaseW-1:0] phase;
  logic              hit;
  lane_out_t         lane_q;
  lane_out_t         lane_d;

  assign hit   = render_i && held_i;
  assign phase = acc_q[oct_i];

  // The phase wraps naturally at the table length in the register width.
  always_comb begin
    acc_d = acc_q;
    if (hit) begin
      acc_d[oct_i] = phase + inc_q[oct_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int o = 0; o < Octaves; o++) begin
        acc_q[o] <= '0;
      end
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int o = 0; o < Octaves; o++) begin
      if (load_we_i[o]) begin
        inc_q[o] <= PhaseW'(step_value_i);
      end
    end
  end

  always_comb begin
    lane_d.held   = hit;
    lane_d.sample = hit ? sine_lookup(rom_addr(phase[PhaseW-1:PhaseFracBits])) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

`default_nettype wire

[src/pdm_mixer.sv]
// ----------------------------------------------------------------------------
// pdm_mixer
// Merges the lane samples: sum, volume gain, divide, clamp and DAC mapping.
// ----------------------------------------------------------------------------
`default_nettype none

module pdm_mixer import pdm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lane_out_t        lane_i [Keys],
  input  logic             valid_i,
  input  logic [VolW-1:0]  volume_i,
  output logic             take_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [DacW-1:0]  dac_sample_o,
  output logic [CountW-1:0] active_count_o
);

  localparam int NumStages = 5;

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] v_d;
  logic [NumStages-1:0] en;

  // Stage 1: partial sums over groups of lanes.
  logic signed [SumW-1:0] grp_sum  [NumGroups];
  logic signed [SumW-1:0] s1_grp_q [NumGroups];
  logic [CntW-1:0]        cnt_sum;
  logic [CntW-1:0]        s1_cnt_q;
  logic [VolW-1:0]        s1_vol_q;

  // Stage 2: sign and magnitude of the total.
  logic signed [SumW-1:0] total;
  logic                   s2_neg_q;
  logic [MagW-1:0]        s2_mag_q;
  logic [CntW-1:0]        s2_cnt_q;
  logic [VolW-1:0]        s2_vol_q;

  // Stage 3: gain product.
  logic                   s3_neg_q;
  logic [ProdW-1:0]       s3_prod_q;
  logic [CntW-1:0]        s3_cnt_q;

  // Stage 4: reciprocal estimate.
  logic                   s4_neg_q;
  logic [ProdW-1:0]       s4_prod_q;
  logic [EstW-1:0]        s4_est_q;
  logic [CntW-1:0]        s4_cnt_q;

  // Stage 5: quotient fix-up and output.
  logic [QW-1:0]          q0;
  logic [ProdW:0]         corr;
  logic [ProdW:0]         rem;
  logic [QW:0]            q1;
  logic [16:0]            biased;
  logic [DacW-1:0]        dac_d;
  logic [DacW-1:0]        dac_q;
  logic [CntW-1:0]        cnt_q;

  // A stage takes new data when it is empty or its successor moves on.
  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || !out_stall_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  always_comb begin
    v_d[0] = en[0] ? valid_i : v_q[0];
    for (int i = 1; i < NumStages; i++) begin
      v_d[i] = en[i] ? v_q[i-1] : v_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign take_o = en[0];

  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      grp_sum[g] = '0;
    end
    cnt_sum = '0;
    for (int k = 0; k < Keys; k++) begin
      grp_sum[k / GroupSize] = grp_sum[k / GroupSize]
                               + SumW'($signed(lane_i[k].sample));
      cnt_sum = cnt_sum + CntW'(lane_i[k].held);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_grp_q <= grp_sum;
      s1_cnt_q <= cnt_sum;
      s1_vol_q <= volume_i;
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < NumGroups; g++) begin
      total = total + s1_grp_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_neg_q <= total[SumW-1];
      s2_mag_q <= total[SumW-1] ? MagW'(-total) : MagW'(total);
      s2_cnt_q <= s1_cnt_q;
      s2_vol_q <= s1_vol_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_neg_q  <= s2_neg_q;
      s3_prod_q <= ProdW'(s2_mag_q) * ProdW'(s2_vol_q);
      s3_cnt_q  <= s2_cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_neg_q  <= s3_neg_q;
      s4_prod_q <= s3_prod_q;
      s4_est_q  <= EstW'(s3_prod_q) * EstW'(MixRecip);
      s4_cnt_q  <= s3_cnt_q;
    end
  end

  // The estimate is the true quotient or one below it; the remainder decides.
  // Truncation toward zero follows from dividing the magnitude.
  always_comb begin
    q0   = s4_est_q[EstW-1:RecipShift];
    corr = (ProdW+1)'(q0) * (ProdW+1)'(MixDivisor);
    rem  = {1'b0, s4_prod_q} - corr;
    q1   = (QW+1)'(q0) + (QW+1)'(rem >= (ProdW+1)'(MixDivisor));
    if (s4_neg_q) begin
      if (q1 >= (QW+1)'(DacMid)) begin
        biased = '0;
      end else begin
        biased = 17'(DacMid) - 17'(q1);
      end
    end else begin
      if (q1 > (QW+1)'(SampleMax)) begin
        biased = 17'(SampleMax + DacMid);
      end else begin
        biased = 17'(q1) + 17'(DacMid);
      end
    end
    dac_d = biased[15:8];
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      dac_q <= dac_d;
      cnt_q <= s4_cnt_q;
    end
  end

  assign out_valid_o    = v_q[NumStages-1];
  assign dac_sample_o   = dac_q;
  assign active_count_o = CountW'(cnt_q);

endmodule

`default_nettype wire

[src/polyphonic_dds_mixer.sv]
// ----------------------------------------------------------------------------
// polyphonic_dds_mixer
// Bank of sine oscillators, one lane per key, mixed to an unsigned DAC byte.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake               | Payload
//   --------+-------------------------+-----------------------------------------
//   in      | in_valid_i / in_stall_o | operation, key_mask, octave, volume,
//           |                         | step_index, step_value
//   out     | out_valid_o/out_stall_i | dac_sample, active_count
//
// One request is taken per clock while in_stall_o is low. A render request
// shows its result after the lane register, which loads at the accepting
// edge, and then five merge stages.
// A load request writes its phase increment at acceptance and gives no result.
// Reset clears all phase accumulators and the pipeline valid flags at once.
// A stall at the output fills empty pipeline stages before the input stalls.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polyphonic_dds_mixer_macros.svh"

module polyphonic_dds_mixer import pdm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic [MaskW-1:0]    key_mask_i,
  input  logic [OctaveW-1:0]  octave_i,
  input  logic [VolW-1:0]     volume_i,
  input  logic [StepIdxW-1:0] step_index_i,
  input  logic [StepW-1:0]    step_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [DacW-1:0]     dac_sample_o,
  output logic [CountW-1:0]   active_count_o
);

  logic               en0;
  logic               accept;
  logic               render;
  logic               load;
  logic               s0_valid_q;
  logic               s0_valid_d;
  logic [VolW-1:0]    vol_q;
  logic [OctSelW-1:0] oct_sel;
  logic               mix_take;
  lane_out_t          lanes [Keys];

  assign en0        = !s0_valid_q || mix_take;
  assign in_stall_o = !en0;
  assign accept     = in_valid_i && en0;
  assign render     = accept && (op_e'(operation_i) == OpRender);
  assign load       = accept && (op_e'(operation_i) == OpLoad);

  // Octaves beyond the bank fall back to the top group.
  assign oct_sel = (32'(octave_i) >= Octaves) ? OctSelW'(Octaves - 1) : OctSelW'(octave_i);

  always_comb begin
    s0_valid_d = s0_valid_q;
    if (en0) begin
      s0_valid_d = render;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= s0_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0) begin
      vol_q <= volume_i;
    end
  end

  for (genvar k = 0; k < Keys; k++) begin : g_lane
    logic               held;
    logic [Octaves-1:0] load_we;

    if (k < MaskW) begin : g_key
      assign held = key_mask_i[k];
    end else begin : g_nokey
      assign held = 1'b0;
    end

    // An index past the bank matches no oscillator and is dropped.
    for (genvar o = 0; o < Octaves; o++) begin : g_we
      assign load_we[o] = load && (32'(step_index_i) == k + Keys * o);
    end

    pdm_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .en_i         (en0),
      .render_i     (render),
      .held_i       (held),
      .oct_i        (oct_sel),
      .load_we_i    (load_we),
      .step_value_i (step_value_i),
      .lane_o       (lanes[k])
    );
  end

  pdm_mixer u_mixer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .lane_i         (lanes),
    .valid_i        (s0_valid_q),
    .volume_i       (vol_q),
    .take_o         (mix_take),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .dac_sample_o   (dac_sample_o),
    .active_count_o (active_count_o)
  );

  `PDM_ASSERT_NXT(a_render_enters, clk_i, rst_ni, render, s0_valid_q, "render request lost")
  `PDM_ASSERT_NXT(a_load_no_item, clk_i, rst_ni, load, !s0_valid_q, "load request entered pipe")
  `PDM_ASSERT_IMP(a_stall_full, clk_i, rst_ni, in_stall_o, s0_valid_q, "stall with empty stage")
  `PDM_ASSERT_IMP(a_silence, clk_i, rst_ni, out_valid_o && active_count_o == '0, dac_sample_o == DacSilence, "no keys but not silent")

endmodule

`default_nettype wire
